// ===== rtl/awn_pkg.sv =====
package awn_pkg;

    // item tags
    typedef enum logic [1:0] {
        TAG_HOST  = 2'd0,
        TAG_LIGHT = 2'd1,
        TAG_AUTO  = 2'd2,
        TAG_ROLL  = 2'd3
    } tag_t;

    // roll direction
    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_OUT  = 2'd1,
        DIR_IN   = 2'd2
    } dir_t;

    // armed setting
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_MAX  = 2'd1,
        PEND_MIN  = 2'd2,
        PEND_THR  = 2'd3
    } pend_t;

    // host command bytes
    localparam logic [7:0] HC_ID        = 8'hff;
    localparam logic [7:0] HC_MODE_Q    = 8'h10;
    localparam logic [7:0] HC_MANUAL    = 8'h20;
    localparam logic [7:0] HC_AUTO      = 8'h30;
    localparam logic [7:0] HC_ROLL_OUT  = 8'h40;
    localparam logic [7:0] HC_ROLL_IN   = 8'h50;
    localparam logic [7:0] HC_LIMITS_Q  = 8'h60;
    localparam logic [7:0] HC_THR_Q     = 8'h70;
    localparam logic [7:0] HC_SET_MAX   = 8'h80;
    localparam logic [7:0] HC_SET_MIN   = 8'h81;
    localparam logic [7:0] HC_SET_THR   = 8'h82;
    localparam logic [7:0] HC_LIGHT_Q   = 8'ha0;
    localparam logic [7:0] HC_EXTENT_Q  = 8'hb0;
    localparam logic [7:0] HC_LT_Q      = 8'hc0;

    localparam logic [7:0] ID_BYTE = 8'hd0;
    localparam logic [7:0] STEP    = 8'd10;

    // lamp bits
    localparam logic [2:0] LAMP_RED    = 3'b001;
    localparam logic [2:0] LAMP_GREEN  = 3'b010;
    localparam logic [2:0] LAMP_YELLOW = 3'b100;

    // reset values
    localparam logic [7:0] RST_MIN = 8'd5;
    localparam logic [7:0] RST_MAX = 8'd160;
    localparam logic [7:0] RST_THR = 8'd25;

    // outcome of one request, handed from core to output queue
    typedef struct packed {
        logic       has_reply;
        logic       two_bytes;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       drop;
        logic [2:0] lamps;
        logic [7:0] extent;
        logic       busy;
    } rec_t;

endpackage

// ===== rtl/awn_item_if.sv =====
interface awn_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] data;

    modport source (output valid, output cmd, output data, input ready);
    modport sink   (input valid, input cmd, input data, output ready);
endinterface

// ===== rtl/awn_result_if.sv =====
interface awn_result_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       lamp_red;
    logic       lamp_green;
    logic       lamp_yellow;
    logic [7:0] extent_now;
    logic       busy_rolling;
    logic       dropped;

    modport source (output valid, output tx_valid, output tx_byte, output last,
                    output lamp_red, output lamp_green, output lamp_yellow,
                    output extent_now, output busy_rolling, output dropped,
                    input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input last,
                    input lamp_red, input lamp_green, input lamp_yellow,
                    input extent_now, input busy_rolling, input dropped,
                    output ready);
endinterface

// ===== rtl/awn_core.sv =====
module awn_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [1:0]    cmd,
    input  logic [7:0]    data,
    output awn_pkg::rec_t rec
);

    logic           auto_reg,   auto_next;
    logic [7:0]     extent_reg, extent_next;
    logic [7:0]     min_reg,    min_next;
    logic [7:0]     max_reg,    max_next;
    logic [7:0]     thr_reg,    thr_next;
    logic [7:0]     light_reg,  light_next;
    awn_pkg::dir_t  dir_reg,    dir_next;
    logic           blink_reg,  blink_next;
    awn_pkg::pend_t pend_reg,   pend_next;
    logic [2:0]     lamps_reg,  lamps_next;

    // next state and outcome of the current request
    always_comb
    begin
        logic       start_out;
        logic       start_in;
        logic [8:0] sum9;
        logic [8:0] floor9;
        start_out   = 1'b0;
        start_in    = 1'b0;
        sum9        = {1'b0, extent_reg} + {1'b0, awn_pkg::STEP};
        floor9      = {1'b0, min_reg} + {1'b0, awn_pkg::STEP};
        auto_next   = auto_reg;
        extent_next = extent_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        thr_next    = thr_reg;
        light_next  = light_reg;
        dir_next    = dir_reg;
        blink_next  = blink_reg;
        pend_next   = pend_reg;
        lamps_next  = lamps_reg;
        rec         = '0;

        unique case (awn_pkg::tag_t'(cmd))
            awn_pkg::TAG_HOST:
            begin
                if (dir_reg != awn_pkg::DIR_IDLE)
                begin
                    rec.drop = 1'b1;
                end
                else if (pend_reg != awn_pkg::PEND_NONE)
                begin
                    unique case (pend_reg)
                        awn_pkg::PEND_MAX: max_next = data;
                        awn_pkg::PEND_MIN: min_next = data;
                        default:           thr_next = data;
                    endcase
                    pend_next = awn_pkg::PEND_NONE;
                end
                else
                begin
                    unique case (data)
                        awn_pkg::HC_ID:
                        begin
                            rec.has_reply = 1'b1;
                            rec.b0        = awn_pkg::ID_BYTE;
                        end
                        awn_pkg::HC_MODE_Q:
                        begin
                            rec.has_reply = 1'b1;
                            rec.b0        = {7'd0, auto_reg};
                        end
                        awn_pkg::HC_MANUAL:   auto_next = 1'b0;
                        awn_pkg::HC_AUTO:     auto_next = 1'b1;
                        awn_pkg::HC_ROLL_OUT: start_out = 1'b1;
                        awn_pkg::HC_ROLL_IN:  start_in  = 1'b1;
                        awn_pkg::HC_LIMITS_Q:
                        begin
                            rec.has_reply = 1'b1;
                            rec.two_bytes = 1'b1;
                            rec.b0        = min_reg;
                            rec.b1        = max_reg;
                        end
                        awn_pkg::HC_THR_Q:
                        begin
                            rec.has_reply = 1'b1;
                            rec.b0        = thr_reg;
                        end
                        awn_pkg::HC_SET_MAX: pend_next = awn_pkg::PEND_MAX;
                        awn_pkg::HC_SET_MIN: pend_next = awn_pkg::PEND_MIN;
                        awn_pkg::HC_SET_THR: pend_next = awn_pkg::PEND_THR;
                        awn_pkg::HC_LIGHT_Q:
                        begin
                            rec.has_reply = 1'b1;
                            rec.b0        = light_reg;
                        end
                        awn_pkg::HC_EXTENT_Q:
                        begin
                            rec.has_reply = 1'b1;
                            rec.b0        = extent_reg;
                        end
                        awn_pkg::HC_LT_Q:
                        begin
                            rec.has_reply = 1'b1;
                            rec.two_bytes = 1'b1;
                            rec.b0        = light_reg;
                            rec.b1        = thr_reg;
                        end
                        default: ;
                    endcase
                end
            end
            awn_pkg::TAG_LIGHT:
            begin
                light_next = data;
            end
            awn_pkg::TAG_AUTO:
            begin
                if (auto_reg && dir_reg == awn_pkg::DIR_IDLE)
                begin
                    if (light_reg > thr_reg)
                        start_out = 1'b1;
                    else
                        start_in = 1'b1;
                end
            end
            default:
            begin
                // roll tick: first half lights yellow, second half steps
                if (dir_reg == awn_pkg::DIR_OUT || dir_reg == awn_pkg::DIR_IN)
                begin
                    if (!blink_reg)
                    begin
                        lamps_next = lamps_reg | awn_pkg::LAMP_YELLOW;
                        blink_next = 1'b1;
                    end
                    else
                    begin
                        lamps_next = lamps_reg & ~awn_pkg::LAMP_YELLOW;
                        blink_next = 1'b0;
                        if (dir_reg == awn_pkg::DIR_OUT)
                        begin
                            extent_next = (sum9 > {1'b0, max_reg}) ? max_reg : sum9[7:0];
                            if (!(extent_next < max_reg))
                                dir_next = awn_pkg::DIR_IDLE;
                        end
                        else
                        begin
                            extent_next = ({1'b0, extent_reg} < floor9) ?
                                          min_reg : extent_reg - awn_pkg::STEP;
                            if (!(extent_next > min_reg))
                                dir_next = awn_pkg::DIR_IDLE;
                        end
                    end
                end
            end
        endcase

        // roll start: swap direction lamp, skip roll when already at limit
        if (start_out)
        begin
            lamps_next = ((lamps_reg == awn_pkg::LAMP_RED) ? 3'b000 : lamps_reg)
                         | awn_pkg::LAMP_GREEN;
            blink_next = 1'b0;
            dir_next   = (extent_reg < max_reg) ? awn_pkg::DIR_OUT : awn_pkg::DIR_IDLE;
        end
        if (start_in)
        begin
            lamps_next = ((lamps_reg == awn_pkg::LAMP_GREEN) ? 3'b000 : lamps_reg)
                         | awn_pkg::LAMP_RED;
            blink_next = 1'b0;
            dir_next   = (extent_reg > min_reg) ? awn_pkg::DIR_IN : awn_pkg::DIR_IDLE;
        end

        rec.lamps  = lamps_next;
        rec.extent = extent_next;
        rec.busy   = (dir_next != awn_pkg::DIR_IDLE);
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg   <= 1'b1;
            extent_reg <= 8'd0;
            min_reg    <= awn_pkg::RST_MIN;
            max_reg    <= awn_pkg::RST_MAX;
            thr_reg    <= awn_pkg::RST_THR;
            light_reg  <= 8'd0;
            dir_reg    <= awn_pkg::DIR_IDLE;
            blink_reg  <= 1'b0;
            pend_reg   <= awn_pkg::PEND_NONE;
            lamps_reg  <= 3'b000;
        end
        else if (take)
        begin
            auto_reg   <= auto_next;
            extent_reg <= extent_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            thr_reg    <= thr_next;
            light_reg  <= light_next;
            dir_reg    <= dir_next;
            blink_reg  <= blink_next;
            pend_reg   <= pend_next;
            lamps_reg  <= lamps_next;
        end
    end

    // roll tick while idle leaves the extent alone
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd == awn_pkg::TAG_ROLL && dir_reg == awn_pkg::DIR_IDLE)
        |=> $stable(extent_reg))
        else $error("extent moved on idle roll tick");

    // host bytes during a roll change no setting
    a_drop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd == awn_pkg::TAG_HOST && dir_reg != awn_pkg::DIR_IDLE)
        |=> ($stable(pend_reg) && $stable(max_reg) && $stable(min_reg) && $stable(auto_reg)))
        else $error("host request acted on during roll");

    // an armed setting is consumed by the next accepted host byte when idle
    a_arg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (take && cmd == awn_pkg::TAG_HOST && dir_reg == awn_pkg::DIR_IDLE
         && pend_reg != awn_pkg::PEND_NONE)
        |=> (pend_reg == awn_pkg::PEND_NONE))
        else $error("armed setting not cleared");

endmodule

// ===== rtl/awn_outq.sv =====
module awn_outq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  awn_pkg::rec_t rec,
    output logic          full,
    awn_result_if.source  result
);

    awn_pkg::rec_t fifo_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg,  count_next;
    logic          sub_reg,    sub_next;
    awn_pkg::rec_t head;
    logic          fire;
    logic          pop;

    // head entry drives the result port; two-byte replies go out in two requests
    always_comb
    begin
        head                = fifo_reg[rd_ptr_reg];
        result.valid        = (count_reg != 2'd0);
        result.tx_valid     = head.has_reply;
        result.tx_byte      = sub_reg ? head.b1 : head.b0;
        result.last         = !head.two_bytes || sub_reg;
        result.lamp_red     = head.lamps[0];
        result.lamp_green   = head.lamps[1];
        result.lamp_yellow  = head.lamps[2];
        result.extent_now   = head.extent;
        result.busy_rolling = head.busy;
        result.dropped      = head.drop;
        full                = (count_reg == 2'd2);
        fire                = result.valid && result.ready;
        pop                 = fire && result.last;
    end

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
        sub_next    = pop ? 1'b0 : (fire ? 1'b1 : sub_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= rec;
    end

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count overflow");

    a_sub_two: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> (result.valid && head.two_bytes))
        else $error("second byte without two-byte entry");

    a_second: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !result.last) |=> (sub_reg && result.valid))
        else $error("second byte lost");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");

endmodule

// ===== rtl/awning_roll_controller_top.sv =====
// channel  | dir | payload                                          | accepted when
// item     | in  | cmd, data                                        | valid && ready
// result   | out | tx_valid, tx_byte, last, lamps, extent_now,      | valid && ready
//          |     | busy_rolling, dropped                            |
//
// One request per cycle while item.ready is high: the controller state updates in the
// accept cycle and the outcome lands in a two-entry result queue. A two-byte reply
// leaves the result port as two transfers, first b0 and then b1 with last set.
// Reset clears all controller registers to their power-on values and empties the queue.
// item.ready drops only while the result queue holds two entries.
module awning_roll_controller_top (
    input  logic         clk,
    input  logic         rst_n,
    awn_item_if.sink     item,
    awn_result_if.source result
);

    awn_pkg::rec_t rec;
    logic          full;
    logic          take;

    assign item.ready = !full;
    assign take       = item.valid && !full;

    awn_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .cmd   (item.cmd),
        .data  (item.data),
        .rec   (rec)
    );

    awn_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (take),
        .rec    (rec),
        .full   (full),
        .result (result)
    );

endmodule
